// ----- sv/pkmr_pkg.sv -----
// Shared types and constants for the packet keyword match and replace block.
package pkmr_pkg;

    // Widest keyword the datapath lanes are built for, in bytes.
    localparam int LANES    = 8;
    localparam int BUS_W    = LANES * 8;
    localparam int CNT_W    = $clog2(LANES + 1);
    localparam int IDX_W    = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_KEY_PATTERN     = 2'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LEN         = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPLACE_PATTERN = 2'd2;
    localparam logic [IDX_W-1:0] REG_REPLACE_ENABLE  = 2'd3;

    typedef struct packed {
        logic [BUS_W-1:0] key_pattern;
        logic [3:0]       key_len;
        logic [BUS_W-1:0] replace_pattern;
        logic             replace_enable;
    } cfg_t;

    // Bytes released by one input beat, oldest in the lowest lane.
    typedef struct packed {
        logic [BUS_W-1:0] bytes;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic             found;
        logic             drop;
    } bundle_t;

endpackage

// ----- sv/pkmr_front.sv -----
// Front end: byte window, parallel keyword compare, replacement and release.
module pkmr_front #(
    parameter int KEY_MAX = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pkmr_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           in_ready,
    input  logic                           q_full,
    output logic                           q_push,
    output pkmr_pkg::bundle_t              q_data
);

    localparam int FILL_W = $clog2(KEY_MAX + 1);
    localparam int WIN_W  = KEY_MAX * 8;
    localparam int BUS_W  = pkmr_pkg::BUS_W;
    localparam int CNT_W  = pkmr_pkg::CNT_W;

    logic [WIN_W-1:0]  window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              found_reg, found_next;

    logic [CNT_W-1:0]  kk, f, d, cnt;
    logic [BUS_W-1:0]  w_flat, v, vr, u, low_mask, rest;
    logic              ge, try_match, miss, hit, found_any;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        // Saturate the key length to the window depth.
        if (cfg.key_len > CNT_W'(KEY_MAX)) begin
            kk = CNT_W'(KEY_MAX);
        end else begin
            kk = cfg.key_len;
        end

        // Append the new byte behind the held ones.
        w_flat = BUS_W'(window_reg);
        for (int i = 0; i < KEY_MAX; i++) begin
            if (CNT_W'(i) == CNT_W'(fill_reg)) begin
                w_flat[i*8 +: 8] = in_byte;
            end
        end
        f = CNT_W'(fill_reg) + CNT_W'(1);

        // Bytes beyond a shortened key leave at once.
        d  = (f > kk) ? (f - kk) : '0;
        ge = (f >= kk);
        v  = w_flat >> {d, 3'b000};

        try_match = (kk != '0) && ge && !found_reg;
        miss      = 1'b0;
        for (int i = 0; i < pkmr_pkg::LANES; i++) begin
            if ((CNT_W'(i) < kk) && (v[i*8 +: 8] != cfg.key_pattern[i*8 +: 8])) begin
                miss = 1'b1;
            end
        end
        hit       = try_match && !miss;
        found_any = found_reg || hit;

        vr       = v;
        low_mask = '0;
        for (int i = 0; i < pkmr_pkg::LANES; i++) begin
            if (hit && cfg.replace_enable && (CNT_W'(i) < kk)) begin
                vr[i*8 +: 8] = cfg.replace_pattern[i*8 +: 8];
            end
            if (CNT_W'(i) < d) begin
                low_mask[i*8 +: 8] = 8'hff;
            end
        end
        u = (w_flat & low_mask) | (vr << {d, 3'b000});

        // Release count: everything on the last byte, else the overflow plus one.
        if (in_last) begin
            cnt = f;
        end else if (ge) begin
            cnt = (kk == '0) ? f : (f - kk + CNT_W'(1));
        end else begin
            cnt = '0;
        end
        rest = u >> {cnt, 3'b000};

        window_next = window_reg;
        fill_next   = fill_reg;
        found_next  = found_reg;
        if (accept) begin
            window_next = rest[WIN_W-1:0];
            fill_next   = in_last ? '0 : FILL_W'(f - cnt);
            found_next  = in_last ? 1'b0 : found_any;
        end

        q_push        = accept && (cnt != '0);
        q_data.bytes  = u;
        q_data.cnt    = cnt;
        q_data.last   = in_last;
        q_data.found  = in_last && found_any;
        q_data.drop   = in_last && found_any && !cfg.replace_enable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fill_reg   <= '0;
            found_reg  <= 1'b0;
        end else begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            found_reg  <= found_next;
        end
    end

endmodule

// ----- sv/pkmr_fifo.sv -----
// Short queue of released byte bundles between front and back end.
module pkmr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pkmr_pkg::bundle_t   wr_data,
    input  logic                pop,
    output pkmr_pkg::bundle_t   rd_data,
    output logic                full,
    output logic                empty
);

    localparam int QPTR_W = pkmr_pkg::QPTR_W;
    localparam int QCNT_W = pkmr_pkg::QCNT_W;

    pkmr_pkg::bundle_t         mem_reg [pkmr_pkg::QDEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         count_reg, count_next;
    logic                      do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(pkmr_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/pkmr_back.sv -----
// Back end: serialize queued bundles into output beats, one byte each.
module pkmr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  pkmr_pkg::bundle_t   q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte
    output logic                m_tlast,   // out_last
    output logic [1:0]          m_tuser    // [0] found, [1] drop
);

    localparam int CNT_W = pkmr_pkg::CNT_W;

    pkmr_pkg::bundle_t cur_reg, cur_next;
    logic              taking, done, final_beat;

    assign m_tvalid   = (cur_reg.cnt != '0);
    assign final_beat = (cur_reg.cnt == CNT_W'(1));
    assign taking     = m_tvalid && m_tready;
    assign done       = !m_tvalid || (taking && final_beat);
    assign q_pop      = done && !q_empty;

    assign m_tdata    = cur_reg.bytes[7:0];
    assign m_tlast    = cur_reg.last && final_beat;
    assign m_tuser    = {cur_reg.drop && m_tlast, cur_reg.found && m_tlast};

    always_comb begin
        cur_next = cur_reg;
        if (done) begin
            if (!q_empty) begin
                cur_next = q_data;
            end else begin
                cur_next.cnt = '0;
            end
        end else if (taking) begin
            cur_next.bytes = cur_reg.bytes >> 8;
            cur_next.cnt   = cur_reg.cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.cnt <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

endmodule

// ----- sv/packet_keyword_match_replace.sv -----
// Top level of the packet keyword match and replace block.
//
// Packet bytes stream in on the s_ side, one byte per beat, and leave on the
// m_ side in their original order. The block holds the most recent key_len
// bytes in a window and compares them in parallel against key_pattern; the
// first match in a packet is overwritten with replace_pattern when
// replace_enable is set, otherwise the packet is only flagged. A byte leaves
// key_len - 1 input beats after it arrived; the last input beat of a packet
// releases the whole window, and the final output beat carries found and
// drop in m_tuser. Throughput is one byte per cycle in steady state: the
// front end takes a beat every cycle the four-entry bundle queue has room,
// and the back end drains one byte per cycle while m_tready is high. A
// packet end releases up to key_len bytes at once, which the back end shifts
// out one byte per accepted beat, so short packets with long keys throttle
// the input while it catches up. Configuration writes are registered
// (cfg_ready is always high); write only while the block is idle. A key_len
// of zero passes bytes through unchanged.
module packet_keyword_match_replace #(
    parameter int KEY_MAX = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // data_byte
    input  logic                      s_tlast,   // last_byte

    // Output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // out_byte
    output logic                      m_tlast,   // out_last
    output logic [1:0]                m_tuser,   // [0] found, [1] drop

    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pkmr_pkg::IDX_W-1:0] cfg_index,
    input  logic [pkmr_pkg::BUS_W-1:0] cfg_data
);

    pkmr_pkg::cfg_t    cfg_reg, cfg_next;
    pkmr_pkg::bundle_t push_data, head_data;
    logic              q_push, q_pop, q_full, q_empty;

    // Register file: always ready, one write per beat.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pkmr_pkg::REG_KEY_PATTERN:     cfg_next.key_pattern     = cfg_data;
                pkmr_pkg::REG_KEY_LEN:         cfg_next.key_len         = cfg_data[3:0];
                pkmr_pkg::REG_REPLACE_PATTERN: cfg_next.replace_pattern = cfg_data;
                pkmr_pkg::REG_REPLACE_ENABLE:  cfg_next.replace_enable  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: window, compare, replace; push released bytes as a bundle.
    pkmr_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // Decouple the front end from output backpressure.
    pkmr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (push_data),
        .pop      (q_pop),
        .rd_data  (head_data),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back end: hold a bundle and advance one byte per accepted beat.
    pkmr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (head_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- test/packet_keyword_match_replace_tb.sv -----
// Self-checking testbench for the packet keyword match and replace block.
`timescale 1ns / 100ps

module packet_keyword_match_replace_tb;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last expected byte before touching registers.
    localparam int SETTLE      = 16;
    localparam int PKT_MAX     = 24;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pkt_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       found;
        logic       drop;
    } out_byte_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata   = '0;   // data_byte
    logic                         s_tlast   = 1'b0; // last_byte
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [7:0]                   m_tdata;          // out_byte
    logic                         m_tlast;          // out_last
    logic [1:0]                   m_tuser;          // [0] found, [1] drop
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [pkmr_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [pkmr_pkg::BUS_W-1:0]   cfg_data  = '0;

    // Register shadow, updated when a write beat is taken.
    logic [pkmr_pkg::BUS_W-1:0]   key_bytes_cfg  = '0;
    logic [3:0]                   key_len_cfg    = '0;
    logic [pkmr_pkg::BUS_W-1:0]   repl_bytes_cfg = '0;
    logic                         repl_en_cfg    = 1'b0;

    // Shadow of the match window.
    logic [7:0]          win_bytes [pkmr_pkg::LANES];
    int                  win_fill   = 0;
    logic                key_seen   = 1'b0;

    pkt_byte_t           pending_bytes  [$];
    out_byte_t           expected_bytes [$];
    pkt_byte_t           next_byte;
    logic                byte_on_bus = 1'b0;
    int                  idle_pct    = 6;
    int                  err_count   = 0;
    int                  stall_cycles = 0;

    packet_keyword_match_replace #(.KEY_MAX(pkmr_pkg::LANES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hold reset low from time zero, then release it for good.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Shift the oldest window byte out as an expected output byte.
    function automatic void release_oldest();
        logic [7:0] oldest;
        oldest = win_bytes[0];
        for (int i = 1; i < pkmr_pkg::LANES; i++) begin
            if (i < win_fill) win_bytes[i-1] = win_bytes[i];
        end
        expected_bytes.push_back({oldest, 3'b000});
        win_fill--;
    endfunction

    // Advance the window by one accepted input byte and queue what leaves it.
    function automatic void advance_window(logic [7:0] b, logic last);
        int        k;
        logic      hit;
        out_byte_t tail;
        k = (key_len_cfg > pkmr_pkg::LANES) ? pkmr_pkg::LANES : int'(key_len_cfg);
        if (win_fill >= pkmr_pkg::LANES) release_oldest();
        win_bytes[win_fill] = b;
        win_fill++;
        // A shorter key than the window holds pushes the excess out at once.
        while (win_fill > k) release_oldest();
        if (k > 0 && win_fill == k && !key_seen) begin
            hit = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (win_bytes[i] != key_bytes_cfg[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                key_seen = 1'b1;
                // Overwritten bytes are never compared again in this packet,
                // since only the first hit counts.
                if (repl_en_cfg) begin
                    for (int i = 0; i < k; i++) win_bytes[i] = repl_bytes_cfg[8*i +: 8];
                end
            end
        end
        if (last) begin
            // Flush the window; the final byte carries the packet verdict.
            while (win_fill > 0) release_oldest();
            tail       = expected_bytes.pop_back();
            tail.last  = 1'b1;
            tail.found = key_seen;
            tail.drop  = key_seen && !repl_en_cfg;
            expected_bytes.push_back(tail);
            key_seen   = 1'b0;
        end else if (k > 0 && win_fill == k) begin
            release_oldest();
        end
    endfunction

    function automatic void check_out_beat();
        out_byte_t want;
        if (expected_bytes.size() == 0) begin
            $error("out_byte: expected none, got %h", m_tdata);
            err_count++;
        end else begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.data) begin
                $error("out_byte: expected %h, got %h", want.data, m_tdata);
                err_count++;
            end
            if (m_tlast !== want.last) begin
                $error("out_last: expected %b, got %b", want.last, m_tlast);
                err_count++;
            end
            if (m_tuser[0] !== want.found) begin
                $error("found: expected %b, got %b", want.found, m_tuser[0]);
                err_count++;
            end
            if (m_tuser[1] !== want.drop) begin
                $error("drop: expected %b, got %b", want.drop, m_tuser[1]);
                err_count++;
            end
        end
    endfunction

    // Driver: predict on every taken beat, then load the next pending byte
    // unless this cycle is picked as a gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            byte_on_bus = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_window(s_tdata, s_tlast);
                byte_on_bus = 1'b0;
            end
            if (!byte_on_bus) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_byte   = pending_bytes.pop_front();
                    s_tdata     <= next_byte.data;
                    s_tlast     <= next_byte.last;
                    s_tvalid    <= 1'b1;
                    byte_on_bus = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken output beat, stall the output at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_out_beat();
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Count cycles in which no channel moves a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void push_byte(logic [7:0] d, logic l);
        pending_bytes.push_back({d, l});
    endfunction

    // Hold the sender until every queued byte went in and every expected
    // byte came out, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_on_bus || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [pkmr_pkg::IDX_W-1:0] idx,
                             input logic [pkmr_pkg::BUS_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pkmr_pkg::REG_KEY_PATTERN:     key_bytes_cfg  = val;
            pkmr_pkg::REG_KEY_LEN:         key_len_cfg    = val[3:0];
            pkmr_pkg::REG_REPLACE_PATTERN: repl_bytes_cfg = val;
            pkmr_pkg::REG_REPLACE_ENABLE:  repl_en_cfg    = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [pkmr_pkg::BUS_W-1:0] kp, input logic [3:0] kl,
                                input logic [pkmr_pkg::BUS_W-1:0] rp, input logic re);
        wait_drained();
        cfg_write(pkmr_pkg::REG_KEY_PATTERN, kp);
        cfg_write(pkmr_pkg::REG_KEY_LEN, pkmr_pkg::BUS_W'(kl));
        cfg_write(pkmr_pkg::REG_REPLACE_PATTERN, rp);
        cfg_write(pkmr_pkg::REG_REPLACE_ENABLE, pkmr_pkg::BUS_W'(re));
    endtask

    // Build one packet: mostly random bytes with the key planted at a random
    // offset, sometimes twice, sometimes with one bit flipped, else pure noise.
    task automatic queue_packet(input int k, output int len);
        logic [7:0] pkt [PKT_MAX];
        int         mode;
        int         off;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, PKT_MAX) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) pkt[i] = 8'($urandom);
        mode = $urandom_range(99);
        if (k > 0 && len >= k && mode < 80) begin
            off = $urandom_range(0, len - k);
            for (int i = 0; i < k; i++) pkt[off+i] = key_bytes_cfg[8*i +: 8];
            if (mode < 15) begin
                off = off + $urandom_range(0, k - 1);
                pkt[off] = pkt[off] ^ 8'(1 << $urandom_range(0, 7));
            end else if (mode < 40 && off + 2*k <= len) begin
                for (int i = 0; i < k; i++) pkt[off+k+i] = key_bytes_cfg[8*i +: 8];
            end
        end
        for (int i = 0; i < len; i++) push_byte(pkt[i], i == len - 1);
    endtask

    initial begin
        logic [pkmr_pkg::BUS_W-1:0] kp;
        logic [pkmr_pkg::BUS_W-1:0] rp;
        logic [3:0]                 kl;
        logic                       re;
        int                         rand_bytes;
        int                         phase_bytes;
        int                         len;
        int                         phase;
        logic                       paused;

        for (int i = 0; i < pkmr_pkg::LANES; i++) win_bytes[i] = '0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Key length zero: bytes pass straight through; extremes of the byte.
        apply_config('0, 4'd0, '0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h5A, 1'b1);

        // Key length above the lane count saturates to eight; replace a full
        // eight-byte key, then the trailing byte flushes the window.
        kp = 64'hFF00_7F80_01FE_A5C3;
        apply_config(kp, 4'd15, 64'h0011_2233_4455_6677, 1'b1);
        for (int i = 0; i < pkmr_pkg::LANES; i++) push_byte(kp[8*i +: 8], 1'b0);
        push_byte(8'h00, 1'b1);

        // One-byte key, filter only: a second hit in the packet is ignored.
        apply_config(64'h42, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h17, 1'b0);
        push_byte(8'h42, 1'b1);

        // Shorten the key in the middle of a packet, between two bytes.
        apply_config(64'h4433_2211, 4'd4, 64'hBBAA, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        wait_drained();
        cfg_write(pkmr_pkg::REG_KEY_LEN, pkmr_pkg::BUS_W'(4'd2));
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);

        // Random phases, each with fresh register settings.
        rand_bytes = 0;
        phase      = 0;
        paused     = 1'b0;
        while (rand_bytes < 125) begin
            kp = {$urandom, $urandom};
            rp = {$urandom, $urandom};
            re = 1'($urandom_range(1));
            case (phase)
                0:       kl = 4'd8;
                1:       kl = 4'd1;
                2:       kl = 4'd0;
                3:       kl = 4'd15;
                4: begin
                    kl = 4'd3;
                    kp = '1;
                    rp = '0;
                end
                5: begin
                    kl = 4'd6;
                    kp = '0;
                    rp = '1;
                end
                default: kl = 4'($urandom_range(1, 9));
            endcase
            apply_config(kp, kl, rp, re);
            // Run phase one back to back on both sides, the others with random gaps.
            idle_pct = (phase == 1) ? 0 : 6;
            phase_bytes = 0;
            while (phase_bytes < 20) begin
                queue_packet((kl > pkmr_pkg::LANES) ? pkmr_pkg::LANES : int'(kl), len);
                phase_bytes += len;
                // Stop feeding once until the output side has caught up.
                if (phase == 2 && !paused && phase_bytes >= 12) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            rand_bytes += phase_bytes;
            phase++;
        end

        wait_drained();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
